// ===== hdl/text_console_char_writer_defines.svh =====
// ----------------------------------------------------------------------------
// Text console character writer: assertion macros
// Shared helpers for writing concurrent checks on the console ports.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCW_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCCW_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console character writer: shared package
// Request and response types, character codes and the sequencer microcode.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

	// Request and response payloads.
	typedef struct packed {
		logic       action;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} tccw_req_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [10:0] cursor_position;
		logic [15:0] read_cell;
	} tccw_rsp_t;

	// Action codes.
	localparam logic ACT_PUT  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Character codes with special meaning.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int TAB_STOP = 8;

	localparam logic [7:0]  RESET_COLOR = 8'h07;
	localparam logic [15:0] RESET_CELL  = {RESET_COLOR, CH_SPACE};

	// Sequencer step addresses.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] S_CLEAR  = 4'd0;
	localparam logic [STEP_W-1:0] S_IDLE   = 4'd1;
	localparam logic [STEP_W-1:0] S_DECODE = 4'd2;
	localparam logic [STEP_W-1:0] S_PUT    = 4'd3;
	localparam logic [STEP_W-1:0] S_OUT    = 4'd4;
	localparam logic [STEP_W-1:0] S_READ   = 4'd5;
	localparam logic [STEP_W-1:0] S_RDOUT  = 4'd6;
	localparam logic [STEP_W-1:0] S_COPY   = 4'd7;
	localparam logic [STEP_W-1:0] S_DRAIN  = 4'd8;
	localparam logic [STEP_W-1:0] S_FILL   = 4'd9;

	// Counter operations.
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_SRC  = 2'd2;
	localparam logic [1:0] CNT_FILL = 2'd3;

	// Screen write selection.
	localparam logic [1:0] W_NONE  = 2'd0;
	localparam logic [1:0] W_RESET = 2'd1;
	localparam logic [1:0] W_BLANK = 2'd2;
	localparam logic [1:0] W_CHAR  = 2'd3;

	// Screen read selection.
	localparam logic [1:0] R_NONE = 2'd0;
	localparam logic [1:0] R_REQ  = 2'd1;
	localparam logic [1:0] R_CNT  = 2'd2;

	// Jump conditions.
	localparam logic [2:0] J_NEXT     = 3'd0;
	localparam logic [2:0] J_ALWAYS   = 3'd1;
	localparam logic [2:0] J_ACCEPT   = 3'd2;
	localparam logic [2:0] J_READ     = 3'd3;
	localparam logic [2:0] J_SCROLL   = 3'd4;
	localparam logic [2:0] J_CNT_LAST = 3'd5;

	// One control word of the sequencer.
	typedef struct packed {
		logic              req_rdy;
		logic [1:0]        cnt_op;
		logic [1:0]        wsel;
		logic [1:0]        rsel;
		logic              cur_upd;
		logic              out_ld;
		logic              out_cell;
		logic [2:0]        jmp;
		logic [STEP_W-1:0] target;
	} tccw_ctrl_t;

	// Microcode store: one control word for each step.
	function automatic tccw_ctrl_t ucode(input logic [STEP_W-1:0] step);
		tccw_ctrl_t c;
		c        = '0;
		c.jmp    = J_ALWAYS;
		c.target = S_IDLE;
		unique case (step)
			S_CLEAR: begin
				c.wsel   = W_RESET;
				c.cnt_op = CNT_INC;
				c.jmp    = J_CNT_LAST;
				c.target = S_IDLE;
			end
			S_IDLE: begin
				c.req_rdy = 1'b1;
				c.jmp     = J_ACCEPT;
			end
			S_DECODE: begin
				c.jmp    = J_READ;
				c.target = S_READ;
			end
			S_PUT: begin
				c.wsel    = W_CHAR;
				c.cur_upd = 1'b1;
				c.cnt_op  = CNT_SRC;
				c.jmp     = J_SCROLL;
				c.target  = S_COPY;
			end
			S_OUT: begin
				c.out_ld = 1'b1;
				c.jmp    = J_ALWAYS;
				c.target = S_IDLE;
			end
			S_READ: begin
				c.rsel = R_REQ;
				c.jmp  = J_NEXT;
			end
			S_RDOUT: begin
				c.out_ld   = 1'b1;
				c.out_cell = 1'b1;
				c.jmp      = J_ALWAYS;
				c.target   = S_IDLE;
			end
			S_COPY: begin
				c.rsel   = R_CNT;
				c.cnt_op = CNT_INC;
				c.jmp    = J_CNT_LAST;
				c.target = S_DRAIN;
			end
			S_DRAIN: begin
				c.cnt_op = CNT_FILL;
				c.jmp    = J_NEXT;
			end
			S_FILL: begin
				c.wsel   = W_BLANK;
				c.cnt_op = CNT_INC;
				c.jmp    = J_CNT_LAST;
				c.target = S_OUT;
			end
			default: begin
				c.jmp    = J_ALWAYS;
				c.target = S_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// Text console character writer
// Screen store and cursor of a text console, driven by a small microcoded
// sequencer: puts characters, handles tab, newline and backspace, scrolls,
// and reads back single cells.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                         Moves
//  -------  ------------------------------  -------------------------------
//  req      req_valid, req_ready, req       one put or read request
//  rsp      rsp_valid, rsp_ready, rsp       cursor state and read cell
//  cfg      cfg_we, cfg_data                text colour, written at once
//
// A put or a read passes through the decode, work and output steps of the
// sequencer between acceptance and the response. A put that scrolls also
// moves the rows below the status line up by one and blanks the last row,
// one cell per cycle through the single screen memory port pair.
// After reset a clearing pass writes all ROWS*COLUMNS cells with req_ready
// low; colour writes are taken throughout.
// A stalled response holds; the next request is taken once it is taken.
`default_nettype none

module text_console_char_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      req_valid,
	output logic                     req_ready,
	input  wire tccw_pkg::tccw_req_t req,
	output logic                     rsp_valid,
	input  wire                      rsp_ready,
	output tccw_pkg::tccw_rsp_t      rsp,
	input  wire                      cfg_we,
	input  wire  [7:0]               cfg_data
);

	localparam int DEPTH = ROWS * COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(ROWS);
	localparam int RXW   = $clog2(ROWS + 1);
	localparam int CW    = $clog2(COLUMNS);
	localparam int CXW   = $clog2(COLUMNS + tccw_pkg::TAB_STOP);
	localparam int SW    = tccw_pkg::STEP_W;

	// Sequencer and datapath registers.
	logic [SW-1:0]        upc_q;
	logic [AW-1:0]        cnt_q;
	logic [RW-1:0]        row_q;
	logic [CW-1:0]        col_q;
	logic [7:0]           color_q;
	logic                 rsp_valid_q;
	tccw_pkg::tccw_req_t  req_q;
	tccw_pkg::tccw_rsp_t  rsp_q;
	logic [15:0]          rdata_q;
	logic                 cp_valid_s1;
	logic [AW-1:0]        cp_addr_s1;
	logic [15:0]          screen_q [DEPTH];

	tccw_pkg::tccw_ctrl_t ctrl;
	logic [SW-1:0]        upc_n;
	logic                 req_fire;
	logic                 cnt_last;

	// Current control word.
	assign ctrl     = tccw_pkg::ucode(upc_q);
	assign req_fire = req_valid && req_ready;
	assign cnt_last = (cnt_q == AW'(DEPTH - 1));

	assign req_ready = ctrl.req_rdy && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Character decode and cursor advance for a put.
	logic [CXW-1:0] col_x;
	logic [CXW-1:0] col_adv;
	logic [CXW-1:0] col_n;
	logic [RXW-1:0] row_x;
	logic [RXW-1:0] row_adv;
	logic [RXW-1:0] row_n;
	logic [CW-1:0]  wcol;
	logic           put_we;
	logic           put_blank;
	logic           overflow;

	always_comb begin
		col_x     = CXW'(col_q);
		row_x     = RXW'(row_q);
		col_adv   = col_x;
		row_adv   = row_x;
		wcol      = col_q;
		put_we    = 1'b0;
		put_blank = 1'b0;
		unique case (req_q.char_code)
			tccw_pkg::CH_TAB: begin
				col_adv = (col_x | CXW'(tccw_pkg::TAB_STOP - 1)) + CXW'(1);
			end
			tccw_pkg::CH_NL: begin
				row_adv = row_x + RXW'(1);
				col_adv = '0;
			end
			tccw_pkg::CH_BS: begin
				if (col_q != '0) begin
					wcol = col_q - CW'(1);
				end
				col_adv   = CXW'(wcol);
				put_we    = 1'b1;
				put_blank = 1'b1;
			end
			tccw_pkg::CH_NUL: begin
			end
			default: begin
				put_we  = 1'b1;
				col_adv = col_x + CXW'(1);
			end
		endcase
		// Wrap at the line end, then clamp to the last row on overflow.
		col_n = col_adv;
		row_n = row_adv;
		if (col_adv >= CXW'(COLUMNS)) begin
			col_n = '0;
			row_n = row_adv + RXW'(1);
		end
		overflow = (row_n >= RXW'(ROWS));
		if (overflow) begin
			row_n = RXW'(ROWS - 1);
		end
	end

	// Read request range check and address.
	logic          rd_in_range;
	logic [AW-1:0] rd_req_addr;

	always_comb begin
		rd_in_range = (32'(req_q.read_row) < ROWS) && (32'(req_q.read_col) < COLUMNS);
		rd_req_addr = '0;
		if (rd_in_range) begin
			rd_req_addr = AW'(req_q.read_row) * AW'(COLUMNS) + AW'(req_q.read_col);
		end
	end

	// Screen write port: scroll copies take priority over the control word.
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = tccw_pkg::RESET_CELL;
		if (cp_valid_s1) begin
			wr_en   = 1'b1;
			wr_addr = cp_addr_s1;
			wr_data = rdata_q;
		end else begin
			unique case (ctrl.wsel)
				tccw_pkg::W_RESET: begin
					wr_en = 1'b1;
				end
				tccw_pkg::W_BLANK: begin
					wr_en   = 1'b1;
					wr_data = {color_q, tccw_pkg::CH_SPACE};
				end
				tccw_pkg::W_CHAR: begin
					wr_en   = put_we;
					wr_addr = AW'(row_q) * AW'(COLUMNS) + AW'(wcol);
					wr_data = {color_q, put_blank ? tccw_pkg::CH_SPACE : req_q.char_code};
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// Screen read port.
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_q;
		unique case (ctrl.rsel)
			tccw_pkg::R_REQ: begin
				rd_en   = 1'b1;
				rd_addr = rd_req_addr;
			end
			tccw_pkg::R_CNT: begin
				rd_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Screen memory.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			screen_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= screen_q[rd_addr];
		end
	end

	// Next step of the sequencer.
	always_comb begin
		unique case (ctrl.jmp)
			tccw_pkg::J_NEXT:     upc_n = upc_q + SW'(1);
			tccw_pkg::J_ALWAYS:   upc_n = ctrl.target;
			tccw_pkg::J_ACCEPT:   upc_n = req_fire ? upc_q + SW'(1) : upc_q;
			tccw_pkg::J_READ: begin
				upc_n = (req_q.action == tccw_pkg::ACT_READ) ? ctrl.target : upc_q + SW'(1);
			end
			tccw_pkg::J_SCROLL:   upc_n = overflow ? ctrl.target : upc_q + SW'(1);
			tccw_pkg::J_CNT_LAST: upc_n = cnt_last ? ctrl.target : upc_q;
			default:              upc_n = tccw_pkg::S_IDLE;
		endcase
	end

	// Response position from the cursor.
	logic [AW-1:0] pos;
	assign pos = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= tccw_pkg::S_CLEAR;
			cnt_q       <= '0;
			row_q       <= RW'(1);
			col_q       <= '0;
			color_q     <= tccw_pkg::RESET_COLOR;
			rsp_valid_q <= 1'b0;
			cp_valid_s1 <= 1'b0;
		end else begin
			upc_q       <= upc_n;
			cp_valid_s1 <= (ctrl.rsel == tccw_pkg::R_CNT);
			if (cfg_we) begin
				color_q <= cfg_data;
			end
			unique case (ctrl.cnt_op)
				tccw_pkg::CNT_INC:  cnt_q <= cnt_q + AW'(1);
				tccw_pkg::CNT_SRC:  cnt_q <= AW'(2 * COLUMNS);
				tccw_pkg::CNT_FILL: cnt_q <= AW'((ROWS - 1) * COLUMNS);
				default:            cnt_q <= cnt_q;
			endcase
			if (ctrl.cur_upd) begin
				row_q <= RW'(row_n);
				col_q <= CW'(col_n);
			end
			if (ctrl.out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
		cp_addr_s1 <= cnt_q - AW'(COLUMNS);
		if (ctrl.out_ld) begin
			rsp_q.cursor_row      <= 5'(row_q);
			rsp_q.cursor_col      <= 7'(col_q);
			rsp_q.cursor_position <= 11'(pos);
			rsp_q.read_cell       <= (ctrl.out_cell && rd_in_range) ? rdata_q : 16'h0000;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tccw_checker.sv =====
// ----------------------------------------------------------------------------
// Text console character writer: port checker
// Concurrent checks on the console ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_char_writer_defines.svh"

module tccw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      req_valid,
	input wire                      req_ready,
	input wire                      rsp_valid,
	input wire                      rsp_ready,
	input wire tccw_pkg::tccw_rsp_t rsp
);

	// A stalled response stays valid and unchanged.
	`TCCW_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled response changed")

	// No request is taken while a response is waiting and not being taken.
	`TCCW_ASSERT_IMP(a_no_overrun, clk, arst_n, rsp_valid && !rsp_ready, !req_ready, "request taken over a waiting response")

	// A freshly taken request leaves no response waiting in the next cycle.
	`TCCW_ASSERT_NXT(a_rsp_gap, clk, arst_n, req_valid && req_ready, !rsp_valid, "response right after a request")

	// The linear position agrees with the reported row and column.
	`TCCW_ASSERT_IMP(a_pos, clk, arst_n, rsp_valid, (ROWS > 32) || (COLUMNS > 128) || (rsp.cursor_position == 11'(32'(rsp.cursor_row) * COLUMNS + 32'(rsp.cursor_col))), "cursor position mismatch")

	// The cursor never enters the status line.
	`TCCW_ASSERT_IMP(a_row_nz, clk, arst_n, rsp_valid, (ROWS > 32) || (rsp.cursor_row != 5'd0), "cursor on status line")

endmodule

bind text_console_char_writer tccw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tccw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Text console character writer: testbench
// Sends put and read requests to the console through its valid/ready channels
// and keeps its own copy of the screen, the cursor and the text colour. Every
// response is checked field by field against the oldest expected response.
// A short table of directed requests comes first. Random traffic follows in
// several phases, with different colours and different idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	// Package types and codes used below.
	typedef tccw_pkg::tccw_req_t tccw_req_t;
	typedef tccw_pkg::tccw_rsp_t tccw_rsp_t;

	localparam logic        ACT_PUT     = tccw_pkg::ACT_PUT;
	localparam logic        ACT_READ    = tccw_pkg::ACT_READ;
	localparam logic [7:0]  CH_NUL      = tccw_pkg::CH_NUL;
	localparam logic [7:0]  CH_BS       = tccw_pkg::CH_BS;
	localparam logic [7:0]  CH_TAB      = tccw_pkg::CH_TAB;
	localparam logic [7:0]  CH_NL       = tccw_pkg::CH_NL;
	localparam logic [7:0]  CH_SPACE    = tccw_pkg::CH_SPACE;
	localparam int          TAB_STOP    = tccw_pkg::TAB_STOP;
	localparam logic [7:0]  RESET_COLOR = tccw_pkg::RESET_COLOR;
	localparam logic [15:0] RESET_CELL  = tccw_pkg::RESET_CELL;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;

	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_REQUESTS  = 234;
	localparam int DIRECTED_ROWS   = 25;
	localparam int TOTAL_REQUESTS  = RANDOM_PHASES * PHASE_REQUESTS + 100;
	localparam int SETTLE_CYCLES   = 10;
	// Worst case: every request scrolls and waits out long gaps on both sides.
	localparam longint CYCLE_LIMIT = CELLS + 64'd4 * TOTAL_REQUESTS * (CELLS + 100);

	// One line of the directed table; a typed response replaces the prediction.
	typedef struct packed {
		logic       action;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
		logic [7:0] repeats;
		logic       typed;
		tccw_rsp_t  want;
	} directed_row_t;

	localparam tccw_rsp_t NO_RSP = '0;

	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ACT_READ, CH_NUL, 5'd0,  7'd0,   8'd1,  1'b1, {5'd1, 7'd0, 11'd80, RESET_CELL}},
		'{ACT_READ, CH_NUL, 5'd24, 7'd79,  8'd1,  1'b1, {5'd1, 7'd0, 11'd80, RESET_CELL}},
		'{ACT_READ, CH_NUL, 5'd31, 7'd127, 8'd1,  1'b1, {5'd1, 7'd0, 11'd80, 16'h0000}},
		'{ACT_READ, CH_NUL, 5'd25, 7'd0,   8'd1,  1'b1, {5'd1, 7'd0, 11'd80, 16'h0000}},
		'{ACT_READ, CH_NUL, 5'd0,  7'd80,  8'd1,  1'b1, {5'd1, 7'd0, 11'd80, 16'h0000}},
		'{ACT_PUT,  CH_NUL, 5'd0,  7'd0,   8'd1,  1'b1, {5'd1, 7'd0, 11'd80, 16'h0000}},
		'{ACT_PUT,  8'h41,  5'd0,  7'd0,   8'd1,  1'b1, {5'd1, 7'd1, 11'd81, 16'h0000}},
		'{ACT_PUT,  8'hFF,  5'd31, 7'd127, 8'd1,  1'b1, {5'd1, 7'd2, 11'd82, 16'h0000}},
		'{ACT_PUT,  8'h80,  5'd0,  7'd0,   8'd1,  1'b1, {5'd1, 7'd3, 11'd83, 16'h0000}},
		'{ACT_READ, CH_NUL, 5'd1,  7'd1,   8'd1,  1'b1,
			{5'd1, 7'd3, 11'd83, {RESET_COLOR, 8'hFF}}},
		'{ACT_PUT,  CH_TAB, 5'd0,  7'd0,   8'd1,  1'b1, {5'd1, 7'd8, 11'd88, 16'h0000}},
		'{ACT_PUT,  CH_BS,  5'd0,  7'd0,   8'd1,  1'b1, {5'd1, 7'd7, 11'd87, 16'h0000}},
		'{ACT_READ, CH_NUL, 5'd1,  7'd7,   8'd1,  1'b0, NO_RSP},
		'{ACT_PUT,  CH_NL,  5'd0,  7'd0,   8'd1,  1'b1, {5'd2, 7'd0, 11'd160, 16'h0000}},
		'{ACT_PUT,  CH_BS,  5'd0,  7'd0,   8'd1,  1'b1, {5'd2, 7'd0, 11'd160, 16'h0000}},
		'{ACT_PUT,  8'h01,  5'd0,  7'd0,   8'd1,  1'b0, NO_RSP},
		'{ACT_PUT,  CH_NL,  5'd0,  7'd0,   8'd22, 1'b0, NO_RSP},
		'{ACT_PUT,  8'h7E,  5'd0,  7'd0,   8'd1,  1'b0, NO_RSP},
		'{ACT_PUT,  CH_TAB, 5'd0,  7'd0,   8'd9,  1'b0, NO_RSP},
		'{ACT_PUT,  8'h5A,  5'd0,  7'd0,   8'd8,  1'b0, NO_RSP},
		'{ACT_PUT,  CH_TAB, 5'd0,  7'd0,   8'd10, 1'b0, NO_RSP},
		'{ACT_READ, CH_NUL, 5'd23, 7'd72,  8'd1,  1'b0, NO_RSP},
		'{ACT_READ, CH_NUL, 5'd1,  7'd0,   8'd1,  1'b0, NO_RSP},
		'{ACT_PUT,  CH_NL,  5'd0,  7'd0,   8'd1,  1'b0, NO_RSP},
		'{ACT_READ, CH_NUL, 5'd24, 7'd0,   8'd1,  1'b0, NO_RSP}
	};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	tccw_req_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	tccw_rsp_t rsp;
	logic      cfg_we    = 1'b0;
	logic [7:0] cfg_data = '0;

	// Shadow copy of the console state.
	logic [15:0] shadow_screen [CELLS];
	int          shadow_row;
	int          shadow_col;
	logic [7:0]  shadow_color;

	tccw_rsp_t   pending_cursor_rsp [$];
	int          fault_count       = 0;
	int          sender_idle_pct   = 33;
	int          receiver_idle_pct = 54;
	longint      cycles_run        = 0;

	text_console_char_writer #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Free-running clock.
	initial begin
		forever begin
			#6 clk = ~clk;
		end
	end

	// Works out the response to one request and updates the shadow state.
	function automatic tccw_rsp_t predict_console_rsp(input tccw_req_t r);
		tccw_rsp_t o;
		int        lin;
		o = '0;
		if (r.action == ACT_PUT) begin
			case (r.char_code)
				CH_TAB: begin
					shadow_col = shadow_col + TAB_STOP - (shadow_col % TAB_STOP);
				end
				CH_NL: begin
					shadow_row = shadow_row + 1;
					shadow_col = 0;
				end
				CH_BS: begin
					if (shadow_col > 0) begin
						shadow_col = shadow_col - 1;
					end
					shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_color, CH_SPACE};
				end
				CH_NUL: begin
				end
				default: begin
					shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_color, r.char_code};
					shadow_col = shadow_col + 1;
				end
			endcase
			// Wrap at the line end, then scroll everything below the status line.
			if (shadow_col >= COLUMNS) begin
				shadow_col = 0;
				shadow_row = shadow_row + 1;
			end
			if (shadow_row >= ROWS) begin
				shadow_row = ROWS - 1;
				for (int i = COLUMNS; i < (ROWS - 1) * COLUMNS; i++) begin
					shadow_screen[i] = shadow_screen[i + COLUMNS];
				end
				for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
					shadow_screen[i] = {shadow_color, CH_SPACE};
				end
			end
		end else if (r.read_row < ROWS && r.read_col < COLUMNS) begin
			o.read_cell = shadow_screen[int'(r.read_row) * COLUMNS + int'(r.read_col)];
		end
		lin               = shadow_row * COLUMNS + shadow_col;
		o.cursor_row      = shadow_row[4:0];
		o.cursor_col      = shadow_col[6:0];
		o.cursor_position = lin[10:0];
		return o;
	endfunction

	// Reports a failure; only the first few are printed in full.
	task automatic note_fault(input string msg);
		if (fault_count < 10) begin
			$display("mismatch: %s", msg);
		end
		fault_count++;
	endtask

	task automatic compare_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			note_fault($sformatf("%s expected %0h, got %0h", field, want, got));
		end
	endtask

	// Offers one request, with an occasional gap first, and records the
	// expected response once the request is taken.
	task automatic send_request(input tccw_req_t r, input logic typed, input tccw_rsp_t want);
		tccw_rsp_t predicted;
		if ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct) begin
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req       <= r;
		do begin
			@(posedge clk);
		end while (!req_ready);
		predicted = predict_console_rsp(r);
		pending_cursor_rsp.push_back(typed ? want : predicted);
	endtask

	// Holds the sender back until every expected response has come.
	task automatic wait_until_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_cursor_rsp.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Colour writes happen only while the console is idle.
	task automatic set_text_colour(input logic [7:0] colour);
		cfg_we   <= 1'b1;
		cfg_data <= colour;
		@(posedge clk);
		shadow_color = colour;
		cfg_we <= 1'b0;
	endtask

	// Receiver back-pressure.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// Response checker.
	always @(posedge clk) begin
		tccw_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_cursor_rsp.size() == 0) begin
				note_fault($sformatf("response %0h with none expected", rsp));
			end else begin
				want = pending_cursor_rsp.pop_front();
				compare_field("cursor_row", 16'(want.cursor_row), 16'(rsp.cursor_row));
				compare_field("cursor_col", 16'(want.cursor_col), 16'(rsp.cursor_col));
				compare_field("cursor_position", 16'(want.cursor_position),
					16'(rsp.cursor_position));
				compare_field("read_cell", want.read_cell, rsp.read_cell);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles_run <= cycles_run + 1;
		if (cycles_run > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		tccw_req_t  r;
		int         sel;
		logic [7:0] colour;

		for (int i = 0; i < CELLS; i++) begin
			shadow_screen[i] = RESET_CELL;
		end
		shadow_row   = 1;
		shadow_col   = 0;
		shadow_color = RESET_COLOR;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests from the table.
		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			for (int n = 0; n < DIRECTED[row].repeats; n++) begin
				r.action    = DIRECTED[row].action;
				r.char_code = DIRECTED[row].char_code;
				r.read_row  = DIRECTED[row].read_row;
				r.read_col  = DIRECTED[row].read_col;
				send_request(r, DIRECTED[row].typed, DIRECTED[row].want);
			end
		end
		wait_until_drained();

		// Random phases: idling swaps after two phases and stops after four.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: colour = 8'h00;
				1: colour = 8'hFF;
				default: colour = 8'($urandom_range(255));
			endcase
			set_text_colour(colour);
			if (phase < 2) begin
				sender_idle_pct   = 33;
				receiver_idle_pct = 54;
			end else if (phase < 4) begin
				sender_idle_pct   = 54;
				receiver_idle_pct = 33;
			end else begin
				sender_idle_pct   = 0;
				receiver_idle_pct = 0;
			end

			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				// Mostly text with line control; a quarter of reads.
				sel         = $urandom_range(99);
				r.action    = ACT_PUT;
				r.char_code = 8'($urandom_range(255));
				r.read_row  = 5'($urandom_range(31));
				r.read_col  = 7'($urandom_range(127));
				if (sel < 25) begin
					r.action = ACT_READ;
					if ($urandom_range(7) != 0) begin
						r.read_row = 5'($urandom_range(ROWS - 1));
						r.read_col = 7'($urandom_range(COLUMNS - 1));
					end
				end else if (sel < 30) begin
					r.char_code = CH_NL;
				end else if (sel < 36) begin
					r.char_code = CH_TAB;
				end else if (sel < 42) begin
					r.char_code = CH_BS;
				end else if (sel < 45) begin
					r.char_code = CH_NUL;
				end
				send_request(r, 1'b0, NO_RSP);
				if (n == PHASE_REQUESTS / 2) begin
					wait_until_drained();
				end
			end
			wait_until_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && pending_cursor_rsp.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
